>>> hdl/pich_pkg.sv
// Shared types and codes of the point-in-convex-hull test core.
// No dependencies; used by pich_mac, the core and the testbench, not by pich_face_store.
package pich_pkg;

    localparam int CORNERS = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CORNER_LAST = 2'd2;

    localparam logic [1:0] VERDICT_OUTSIDE  = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE   = 2'd1;
    localparam logic [1:0] VERDICT_BOUNDARY = 2'd2;
    localparam logic [1:0] VERDICT_INVALID  = 2'd3;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // Control of the shared multiply-accumulate unit for one product.
    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } t_mac_op;

endpackage

>>> hdl/pich_face_store.sv
// Face corner memory: one write port, one read port with registered data.
// Uses no package items.
module pich_face_store #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pich_mac.sv
// Shared signed multiplier with a registered product and an exact accumulator.
// Depends on pich_pkg for the operation struct.
module pich_mac #(
    parameter int A_W   = 35,
    parameter int B_W   = 17,
    parameter int ACC_W = 54
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    input  pich_pkg::t_mac_op       i_op,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [A_W+B_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   prod_ext;
    pich_pkg::t_mac_op         r_op;

    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
        r_prod <= i_a * i_b;
        if (r_op.en) begin
            if (r_op.clr) begin
                r_acc <= r_op.neg ? -prod_ext : prod_ext;
            end else begin
                r_acc <= r_op.neg ? r_acc - prod_ext : r_acc + prod_ext;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hdl/point_in_convex_hull_test_core.sv
// Point-in-convex-hull test core. A corner load is written when accepted. A query
// walks the faces in order; per face it reads the three corners, then computes
// products through the one shared multiplier, edge tests only for coplanar faces.
// Reset is synchronous, active low; it clears control and face_count, not the store.
module point_in_convex_hull_test_core #(
    parameter int MAX_FACES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [5:0]                   i_face_index,
    input  logic [1:0]                   i_corner,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_verdict,
    input  logic                         i_cfg_we,
    input  logic [6:0]                   i_cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int DW     = C + 1;
    localparam int NW     = 2 * C + 3;
    localparam int AW     = 3 * C + 6;
    localparam int DEPTH  = MAX_FACES * pich_pkg::CORNERS;
    localparam int AD     = $clog2(DEPTH);
    localparam int FI     = $clog2(MAX_FACES);
    localparam int NFW    = $clog2(MAX_FACES + 1);
    localparam int CW     = (NFW > 7) ? NFW : 7;

    localparam logic [4:0] ST_NX_A = 5'd0;
    localparam logic [4:0] ST_NX_B = 5'd1;
    localparam logic [4:0] ST_NY_A = 5'd2;
    localparam logic [4:0] ST_NY_B = 5'd3;
    localparam logic [4:0] ST_NZ_A = 5'd4;
    localparam logic [4:0] ST_NZ_B = 5'd5;
    localparam logic [4:0] ST_DX   = 5'd6;
    localparam logic [4:0] ST_DY   = 5'd7;
    localparam logic [4:0] ST_DZ   = 5'd8;
    localparam logic [4:0] ST_EVAL = 5'd10;
    localparam logic [4:0] ST_E0_A = 5'd11;
    localparam logic [4:0] ST_E0_B = 5'd12;
    localparam logic [4:0] ST_E1_A = 5'd13;
    localparam logic [4:0] ST_E1_B = 5'd14;
    localparam logic [4:0] ST_E2_A = 5'd15;
    localparam logic [4:0] ST_E2_B = 5'd16;
    localparam logic [4:0] ST_E2_V = 5'd18;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC} t_state;

    t_state                r_state;
    logic [1:0]            r_k;
    logic [4:0]            r_s;
    logic [CW-1:0]         r_face;
    logic [CW-1:0]         r_nf;
    logic [6:0]            r_face_count;
    logic [1:0]            r_first;
    logic [1:0]            r_axis;
    logic                  r_nk_neg;
    logic                  r_ovalid;
    logic [1:0]            r_verdict;
    logic signed [C-1:0]   r_px, r_py, r_pz;
    logic signed [C-1:0]   r_ax, r_ay, r_az;
    logic signed [C-1:0]   r_bx, r_by, r_bz;
    logic signed [C-1:0]   r_cx, r_cy, r_cz;
    logic signed [NW-1:0]  r_nx, r_ny, r_nz;

    logic                  in_acc;
    logic                  store_we;
    logic [AD-1:0]         waddr, raddr;
    logic [3*C-1:0]        rdata;
    logic [CW-1:0]         nf_req;
    logic signed [DW-1:0]  ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic signed [NW-1:0]  mac_a;
    logic signed [DW-1:0]  mac_b;
    pich_pkg::t_mac_op     mac_op;
    logic signed [AW-1:0]  acc;
    logic signed [C-1:0]   ox, oy, oz, qx, qy, qz;
    logic signed [C-1:0]   o_u, o_v, q_u, q_v, p_u, p_v;
    logic signed [DW-1:0]  qu, qv, ru, rv;
    logic                  acc_zero, acc_neg, edge_bad;
    logic                  face_done, decide;
    logic [1:0]            decide_verdict;
    logic [1:0]            first_new;
    logic                  last_face;

    assign o_stall   = (r_state != S_IDLE) || r_ovalid;
    assign in_acc    = i_valid && !o_stall;
    assign o_valid   = r_ovalid;
    assign o_verdict = r_verdict;

    assign store_we = in_acc && (i_operation == pich_pkg::OP_LOAD)
                      && (i_corner <= pich_pkg::CORNER_LAST)
                      && (32'(i_face_index) < 32'(MAX_FACES));
    assign waddr = AD'(32'(i_face_index) * pich_pkg::CORNERS + 32'(i_corner));
    assign raddr = AD'(32'(r_face[FI-1:0]) * pich_pkg::CORNERS + 32'(r_k));

    pich_face_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AD),
        .DATA_W (3 * C)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (waddr),
        .i_wdata ({i_coord_x, i_coord_y, i_coord_z}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pich_mac #(
        .A_W   (NW),
        .B_W   (DW),
        .ACC_W (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_op    (mac_op),
        .o_acc   (acc)
    );

    assign nf_req = (CW'(r_face_count) > CW'(MAX_FACES)) ? CW'(MAX_FACES)
                                                         : CW'(r_face_count);

    assign ux = DW'(r_bx) - DW'(r_ax);
    assign uy = DW'(r_by) - DW'(r_ay);
    assign uz = DW'(r_bz) - DW'(r_az);
    assign vx = DW'(r_cx) - DW'(r_ax);
    assign vy = DW'(r_cy) - DW'(r_ay);
    assign vz = DW'(r_cz) - DW'(r_az);
    assign wx = DW'(r_px) - DW'(r_ax);
    assign wy = DW'(r_py) - DW'(r_ay);
    assign wz = DW'(r_pz) - DW'(r_az);

    // Edge of the coplanar triangle test: origin corner and far corner.
    always_comb begin
        case (r_s)
            ST_E0_A, ST_E0_B: begin
                ox = r_ax; oy = r_ay; oz = r_az;
                qx = r_bx; qy = r_by; qz = r_bz;
            end
            ST_E1_A, ST_E1_B: begin
                ox = r_bx; oy = r_by; oz = r_bz;
                qx = r_cx; qy = r_cy; qz = r_cz;
            end
            default: begin
                ox = r_cx; oy = r_cy; oz = r_cz;
                qx = r_ax; qy = r_ay; qz = r_az;
            end
        endcase
        case (r_axis)
            AXIS_Z: begin
                o_u = ox; o_v = oy; q_u = qx; q_v = qy; p_u = r_px; p_v = r_py;
            end
            AXIS_Y: begin
                o_u = oz; o_v = ox; q_u = qz; q_v = qx; p_u = r_pz; p_v = r_px;
            end
            default: begin
                o_u = oy; o_v = oz; q_u = qy; q_v = qz; p_u = r_py; p_v = r_pz;
            end
        endcase
    end

    assign qu = DW'(q_u) - DW'(o_u);
    assign qv = DW'(q_v) - DW'(o_v);
    assign ru = DW'(p_u) - DW'(o_u);
    assign rv = DW'(p_v) - DW'(o_v);

    // Product schedule of one face; each product is registered in the multiplier
    // and then folded into the accumulator.
    always_comb begin
        mac_a  = '0;
        mac_b  = '0;
        mac_op = '0;
        if (r_state == S_CALC) begin
            case (r_s)
                ST_NX_A: begin mac_a = NW'(uy); mac_b = vz; mac_op = '{1'b1, 1'b1, 1'b0}; end
                ST_NX_B: begin mac_a = NW'(uz); mac_b = vy; mac_op = '{1'b1, 1'b0, 1'b1}; end
                ST_NY_A: begin mac_a = NW'(uz); mac_b = vx; mac_op = '{1'b1, 1'b1, 1'b0}; end
                ST_NY_B: begin mac_a = NW'(ux); mac_b = vz; mac_op = '{1'b1, 1'b0, 1'b1}; end
                ST_NZ_A: begin mac_a = NW'(ux); mac_b = vy; mac_op = '{1'b1, 1'b1, 1'b0}; end
                ST_NZ_B: begin mac_a = NW'(uy); mac_b = vx; mac_op = '{1'b1, 1'b0, 1'b1}; end
                ST_DX:   begin mac_a = r_nx; mac_b = wx; mac_op = '{1'b1, 1'b1, 1'b0}; end
                ST_DY:   begin mac_a = r_ny; mac_b = wy; mac_op = '{1'b1, 1'b0, 1'b0}; end
                ST_DZ:   begin mac_a = r_nz; mac_b = wz; mac_op = '{1'b1, 1'b0, 1'b0}; end
                ST_E0_A, ST_E1_A, ST_E2_A: begin
                    mac_a = NW'(qu); mac_b = rv; mac_op = '{1'b1, 1'b1, 1'b0};
                end
                ST_E0_B, ST_E1_B, ST_E2_B: begin
                    mac_a = NW'(qv); mac_b = ru; mac_op = '{1'b1, 1'b0, 1'b1};
                end
                default: mac_op = '0;
            endcase
        end
    end

    assign acc_zero  = (acc == '0);
    assign acc_neg   = acc[AW-1];
    assign edge_bad  = r_nk_neg ? (!acc_neg && !acc_zero) : acc_neg;
    assign last_face = (CW'(r_face + 1'b1) == r_nf);

    // Per-face decision: end the query, or move on to the next face.
    always_comb begin
        face_done      = 1'b0;
        decide         = 1'b0;
        decide_verdict = pich_pkg::VERDICT_INSIDE;
        first_new      = r_first;
        if (r_state == S_CALC) begin
            case (r_s)
                ST_EVAL: begin
                    if (!acc_zero) begin
                        if (r_first == pich_pkg::SIGN_NONE) begin
                            first_new = acc_neg ? pich_pkg::SIGN_NEG : pich_pkg::SIGN_POS;
                            face_done = 1'b1;
                        end else if ((acc_neg ? pich_pkg::SIGN_NEG : pich_pkg::SIGN_POS)
                                     != r_first) begin
                            decide         = 1'b1;
                            decide_verdict = pich_pkg::VERDICT_OUTSIDE;
                        end else begin
                            face_done = 1'b1;
                        end
                    end else if (r_nx == '0 && r_ny == '0 && r_nz == '0) begin
                        // A degenerate face never holds the point.
                        face_done = 1'b1;
                    end
                end
                ST_E1_B, ST_E2_B: face_done = edge_bad;
                ST_E2_V: begin
                    if (edge_bad) begin
                        face_done = 1'b1;
                    end else begin
                        decide         = 1'b1;
                        decide_verdict = pich_pkg::VERDICT_BOUNDARY;
                    end
                end
                default: face_done = 1'b0;
            endcase
            if (face_done && last_face) begin
                decide         = 1'b1;
                decide_verdict = (first_new == pich_pkg::SIGN_NONE)
                                 ? pich_pkg::VERDICT_INVALID : pich_pkg::VERDICT_INSIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= '0;
            r_s          <= '0;
            r_face       <= '0;
            r_nf         <= '0;
            r_face_count <= '0;
            r_first      <= pich_pkg::SIGN_NONE;
            r_ovalid     <= 1'b0;
            r_verdict    <= pich_pkg::VERDICT_INVALID;
        end else begin
            if (i_cfg_we) begin
                r_face_count <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_operation == pich_pkg::OP_QUERY) begin
                        r_px    <= i_coord_x;
                        r_py    <= i_coord_y;
                        r_pz    <= i_coord_z;
                        r_nf    <= nf_req;
                        r_face  <= '0;
                        r_k     <= '0;
                        r_first <= pich_pkg::SIGN_NONE;
                        if (nf_req == '0) begin
                            r_ovalid  <= 1'b1;
                            r_verdict <= pich_pkg::VERDICT_INVALID;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_k <= r_k + 1'b1;
                    case (r_k)
                        2'd1: {r_ax, r_ay, r_az} <= rdata;
                        2'd2: {r_bx, r_by, r_bz} <= rdata;
                        2'd3: begin
                            {r_cx, r_cy, r_cz} <= rdata;
                            r_s     <= ST_NX_A;
                            r_state <= S_CALC;
                        end
                        default: begin
                        end
                    endcase
                end
                S_CALC: begin
                    case (r_s)
                        ST_NY_B: r_nx <= NW'(acc);
                        ST_NZ_B: r_ny <= NW'(acc);
                        ST_DY:   r_nz <= NW'(acc);
                        ST_EVAL: begin
                            // Project onto the plane that drops the first nonzero
                            // normal axis, tried from z down to x.
                            if (r_nz != '0) begin
                                r_axis   <= AXIS_Z;
                                r_nk_neg <= r_nz[NW-1];
                            end else if (r_ny != '0) begin
                                r_axis   <= AXIS_Y;
                                r_nk_neg <= r_ny[NW-1];
                            end else begin
                                r_axis   <= AXIS_X;
                                r_nk_neg <= r_nx[NW-1];
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (decide) begin
                        r_ovalid  <= 1'b1;
                        r_verdict <= decide_verdict;
                        r_state   <= S_IDLE;
                    end else if (face_done) begin
                        r_first <= first_new;
                        r_face  <= CW'(r_face + 1'b1);
                        r_k     <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> test/point_in_convex_hull_test_core_tb.sv
// Self-checking testbench of the point-in-convex-hull test core.
// Depends on pich_pkg and point_in_convex_hull_test_core; a small scoreboard
// class predicts each verdict from its own copy of the face store.
`timescale 1ns / 100ps

module point_in_convex_hull_test_core_tb;

    localparam int FACE_SLOTS = 64;
    localparam longint CYCLE_LIMIT = 20000000;

    // Predicts verdicts from the accepted requests and checks the results.
    class verdict_board;
        longint cx[FACE_SLOTS*pich_pkg::CORNERS];
        longint cy[FACE_SLOTS*pich_pkg::CORNERS];
        longint cz[FACE_SLOTS*pich_pkg::CORNERS];
        bit [6:0] face_count;
        logic [1:0] expected_verdicts[$];
        int errors;

        function new();
            face_count = 0;
            errors = 0;
            foreach (cx[i]) begin
                cx[i] = 0;
                cy[i] = 0;
                cz[i] = 0;
            end
        endfunction

        function void set_face_count(bit [6:0] v);
            face_count = v;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // Projection onto the plane that drops axis k.
        function void project(longint x, longint y, longint z, int k,
                              output longint u, output longint v);
            if (k == 2) begin
                u = x;
                v = y;
            end else if (k == 1) begin
                u = z;
                v = x;
            end else begin
                u = y;
                v = z;
            end
        endfunction

        function longint edge_cross(longint ou, longint ov, longint qu, longint qv,
                                    longint ru, longint rv);
            return (qu - ou) * (rv - ov) - (qv - ov) * (ru - ou);
        endfunction

        function logic [1:0] classify(longint px, longint py, longint pz);
            int nf;
            int k;
            logic [1:0] first_sign;
            logic [1:0] s;
            longint ax, ay, az, bx, by, bz, qx, qy, qz;
            longint ux, uy, uz, vx, vy, vz, nx, ny, nz, nk, det;
            longint au, av, bu, bv, cu, cv, pu, pv, e0, e1, e2;
            nf = (face_count > FACE_SLOTS) ? FACE_SLOTS : face_count;
            first_sign = pich_pkg::SIGN_NONE;
            if (nf == 0) return pich_pkg::VERDICT_INVALID;
            for (int f = 0; f < nf; f++) begin
                ax = cx[f*3];   ay = cy[f*3];   az = cz[f*3];
                bx = cx[f*3+1]; by = cy[f*3+1]; bz = cz[f*3+1];
                qx = cx[f*3+2]; qy = cy[f*3+2]; qz = cz[f*3+2];
                ux = bx - ax; uy = by - ay; uz = bz - az;
                vx = qx - ax; vy = qy - ay; vz = qz - az;
                nx = uy * vz - uz * vy;
                ny = uz * vx - ux * vz;
                nz = ux * vy - uy * vx;
                det = nx * (px - ax) + ny * (py - ay) + nz * (pz - az);
                if (det == 0) begin
                    if (nz != 0) begin
                        k = 2; nk = nz;
                    end else if (ny != 0) begin
                        k = 1; nk = ny;
                    end else if (nx != 0) begin
                        k = 0; nk = nx;
                    end else begin
                        continue;
                    end
                    project(ax, ay, az, k, au, av);
                    project(bx, by, bz, k, bu, bv);
                    project(qx, qy, qz, k, cu, cv);
                    project(px, py, pz, k, pu, pv);
                    e0 = edge_cross(au, av, bu, bv, pu, pv);
                    e1 = edge_cross(bu, bv, cu, cv, pu, pv);
                    e2 = edge_cross(cu, cv, au, av, pu, pv);
                    if (nk > 0 && e0 >= 0 && e1 >= 0 && e2 >= 0)
                        return pich_pkg::VERDICT_BOUNDARY;
                    if (nk < 0 && e0 <= 0 && e1 <= 0 && e2 <= 0)
                        return pich_pkg::VERDICT_BOUNDARY;
                    continue;
                end
                s = (det > 0) ? pich_pkg::SIGN_POS : pich_pkg::SIGN_NEG;
                if (first_sign == pich_pkg::SIGN_NONE) first_sign = s;
                else if (s != first_sign) return pich_pkg::VERDICT_OUTSIDE;
            end
            return (first_sign == pich_pkg::SIGN_NONE) ? pich_pkg::VERDICT_INVALID
                                                       : pich_pkg::VERDICT_INSIDE;
        endfunction

        function void note(logic op, logic [5:0] fi, logic [1:0] cn,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
            if (op == pich_pkg::OP_QUERY) begin
                expected_verdicts.push_back(classify(x, y, z));
            end else if (cn <= pich_pkg::CORNER_LAST) begin
                cx[fi*3+cn] = x;
                cy[fi*3+cn] = y;
                cz[fi*3+cn] = z;
            end
        endfunction

        function void check(logic [1:0] got);
            logic [1:0] want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, got %0d", $time, got);
                errors++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got !== want) begin
                $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_operation = pich_pkg::OP_LOAD;
    logic [5:0]          i_face_index = '0;
    logic [1:0]          i_corner = '0;
    logic signed [15:0]  i_coord_x = '0;
    logic signed [15:0]  i_coord_y = '0;
    logic signed [15:0]  i_coord_z = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [1:0]          o_verdict;
    logic                i_cfg_we = 1'b0;
    logic [6:0]          i_cfg_data = '0;

    verdict_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    longint cycles = 0;

    point_in_convex_hull_test_core #(
        .MAX_FACES(64),
        .COORD_BITS(16)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_face_index(i_face_index),
        .i_corner(i_corner),
        .i_coord_x(i_coord_x),
        .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_verdict(o_verdict),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check accepted verdicts, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check(o_verdict);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send(logic op, logic [5:0] fi, logic [1:0] cn,
                        logic signed [15:0] x, logic signed [15:0] y,
                        logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_face_index <= fi;
        i_corner <= cn;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (o_stall);
        board.note(op, fi, cn, x, y, z);
    endtask

    task automatic query(logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [15:0] z);
        send(pich_pkg::OP_QUERY, 6'($urandom), 2'($urandom), x, y, z);
    endtask

    // The register is written only with the block idle and nothing pending.
    task automatic set_faces(logic [6:0] v);
        i_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_face_count(v);
    endtask

    function automatic int pick(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    // Random tetrahedron in faces 0..3, some noise loads, then queries near it and anywhere.
    task automatic tetra_round(int r, int nq);
        int vx[4], vy[4], vz[4];
        int fa[4], fb[4], fc[4];
        int i, j;
        fa = '{0, 0, 0, 1}; fb = '{2, 1, 3, 2}; fc = '{1, 3, 2, 3};
        for (i = 0; i < 4; i++) begin
            vx[i] = pick(r); vy[i] = pick(r); vz[i] = pick(r);
        end
        for (int f = 0; f < 4; f++) begin
            send(pich_pkg::OP_LOAD, 6'(f), 2'd0, 16'(vx[fa[f]]), 16'(vy[fa[f]]),
                 16'(vz[fa[f]]));
            send(pich_pkg::OP_LOAD, 6'(f), 2'd1, 16'(vx[fb[f]]), 16'(vy[fb[f]]),
                 16'(vz[fb[f]]));
            send(pich_pkg::OP_LOAD, 6'(f), 2'd2, 16'(vx[fc[f]]), 16'(vy[fc[f]]),
                 16'(vz[fc[f]]));
            if ($urandom_range(9) == 0)
                send(pich_pkg::OP_LOAD, 6'($urandom), 2'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        end
        for (int q = 0; q < nq; q++) begin
            i = $urandom_range(3);
            j = $urandom_range(3);
            case ($urandom_range(4))
                0: query(16'(vx[i]), 16'(vy[i]), 16'(vz[i]));
                1: query(16'((vx[i] + vx[j]) / 2), 16'((vy[i] + vy[j]) / 2),
                         16'((vz[i] + vz[j]) / 2));
                2: query(16'($urandom), 16'($urandom), 16'($urandom));
                default: query(16'(pick(r)), 16'(pick(r)), 16'(pick(r)));
            endcase
        end
    endtask

    task automatic set_mode(int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    initial begin
        int counts[8];
        counts = '{4, 8, 4, 1, 64, 4, 127, 4};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No faces in use gives an invalid verdict.
        query(16'sd5, -16'sd5, 16'sd0);
        // Fill the whole store so that any face count reads written corners.
        for (int f = 0; f < FACE_SLOTS; f++)
            for (int c = 0; c < pich_pkg::CORNERS; c++)
                send(pich_pkg::OP_LOAD, 6'(f), 2'(c), 16'($urandom), 16'($urandom),
                     16'($urandom));
        send(pich_pkg::OP_LOAD, 6'd0, 2'd0, 16'sd0, 16'sd0, 16'sd0);
        send(pich_pkg::OP_LOAD, 6'd0, 2'd1, 16'sd0, 16'sd100, 16'sd0);
        send(pich_pkg::OP_LOAD, 6'd0, 2'd2, 16'sd100, 16'sd0, 16'sd0);
        send(pich_pkg::OP_LOAD, 6'd0, 2'd3, 16'sd7, 16'sd7, 16'sd7);
        set_faces(7'd1);
        query(16'sd10, 16'sd10, 16'sd10);
        query(16'sd20, 16'sd20, 16'sd0);
        // A coplanar point off the triangle leaves every face skipped.
        query(16'sd300, 16'sd300, 16'sd0);
        query(-16'sd32768, -16'sd32768, -16'sd32768);
        query(16'sd32767, 16'sd32767, 16'sd32767);
        // Collinear corners never contain the point.
        send(pich_pkg::OP_LOAD, 6'd0, 2'd2, 16'sd0, 16'sd200, 16'sd0);
        query(16'sd0, 16'sd50, 16'sd0);
        query(16'sd1, 16'sd2, 16'sd3);
        send(pich_pkg::OP_LOAD, 6'd0, 2'd2, 16'sd100, 16'sd0, 16'sd0);
        send(pich_pkg::OP_LOAD, 6'd63, 2'd2, -16'sd32768, 16'sd32767, -16'sd1);
        // Counts above the store size walk every face.
        set_faces(7'd127);
        query(16'sd0, 16'sd0, 16'sd0);
        query(16'sd1, -16'sd1, 16'sd1);

        for (int p = 0; p < 8; p++) begin
            set_faces(7'(counts[p]));
            set_mode(p);
            if (p == 0) hold_left = 600;
            if (counts[p] > 8) begin
                tetra_round(6, 3);
                tetra_round(32767, 3);
            end else begin
                for (int r = 0; r < 14; r++)
                    tetra_round((r % 3 == 0) ? 32767 : (r % 3 == 1) ? 4 : 40, 8);
            end
        end
        set_faces(7'd0);
        query(16'sd3, 16'sd3, 16'sd3);
        set_faces(7'd64);
        set_mode(0);
        query(16'sd0, 16'sd0, 16'sd0);

        i_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.pending() > 0) begin
            $display("%0t: verdicts missing, expected %0d more, got none", $time,
                     board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/pich_pkg.sv
hdl/pich_face_store.sv
hdl/pich_mac.sv
hdl/point_in_convex_hull_test_core.sv
test/point_in_convex_hull_test_core_tb.sv
